/* sv/pip_pkg.sv */
// Shared types and constants for the point-in-polygon test block.
// Used by pip_front, pip_edge, pip_walk and point_in_polygon_test.
// No dependencies.
`default_nettype none

package pip_pkg;

  localparam int IDX_W  = 6;   // vertex slot field
  localparam int CRD_W  = 16;  // integer corner coordinate
  localparam int PT_W   = 24;  // Q16.8 query coordinate
  localparam int CNT_W  = 7;   // vertex_count register
  localparam int QDEPTH = 2;   // command queue depth, power of two

  // Register index on the configuration port (paddr[2])
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One queued command, front to back
  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        vidx;
    logic signed [CRD_W-1:0] vx;
    logic signed [CRD_W-1:0] vy;
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
  } cmd_t;

  // One edge into the crossing pipeline: corner a is the current corner,
  // corner b its predecessor.
  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic signed [CRD_W-1:0] xa;
    logic signed [CRD_W-1:0] ya;
    logic signed [CRD_W-1:0] xb;
    logic signed [CRD_W-1:0] yb;
  } seg_t;

  // Crossing verdict out of the pipeline
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } xing_t;

endpackage

`default_nettype wire

/* sv/pip_front.sv */
// Front end: accepts input items, classifies them and queues commands.
// Depends on pip_pkg.
`default_nettype none

module pip_front #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [pip_pkg::IDX_W-1:0]         vertex_index_i,
  input  wire logic signed [pip_pkg::CRD_W-1:0]  vertex_x_i,
  input  wire logic signed [pip_pkg::CRD_W-1:0]  vertex_y_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]   point_x_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]   point_y_i,
  output pip_pkg::cmd_t                          cmd_o,
  output logic                                   cmd_vld_o,
  input  wire logic                              cmd_pop_i
);

  localparam int QAW = $clog2(pip_pkg::QDEPTH);

  pip_pkg::cmd_t    q_mem [pip_pkg::QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q;
  pip_pkg::cmd_t    in_cmd;
  logic             keep;
  logic             push;

  assign in_ready_o = (cnt_q != (QAW+1)'(pip_pkg::QDEPTH));
  assign cmd_vld_o  = (cnt_q != '0);
  assign cmd_o      = q_mem[rd_ptr_q];

  always_comb begin
    in_cmd.op   = pip_pkg::op_e'(func_i);
    in_cmd.vidx = vertex_index_i;
    in_cmd.vx   = vertex_x_i;
    in_cmd.vy   = vertex_y_i;
    in_cmd.px   = point_x_i;
    in_cmd.py   = point_y_i;
  end

  // Drop stores aimed past the end of the vertex memory
  assign keep = (in_cmd.op == pip_pkg::OP_QUERY) || (int'(vertex_index_i) < MAX_VERTICES);
  assign push = in_valid_i && in_ready_o && keep;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      unique case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/pip_edge.sv */
// Crossing pipeline: straddle check and differences, then two multiplies,
// then the signed compare. Depends on pip_pkg.
`default_nettype none

module pip_edge (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pip_pkg::seg_t                    seg_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]  px_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]  py_i,
  output pip_pkg::xing_t                        xing_o
);

  localparam int DW = pip_pkg::CRD_W + 1;   // corner difference
  localparam int RW = pip_pkg::PT_W + 1;    // point minus scaled corner
  localparam int PW = DW + RW;              // product

  logic signed [pip_pkg::PT_W-1:0] ya8, yb8, xa8;
  logic                            straddle;
  logic signed [DW-1:0]            dx_d, dy_d;
  logic signed [RW-1:0]            rx_d, ry_d;

  logic                 s1_vld_q, s1_last_q, s1_str_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic signed [RW-1:0] s1_rx_q, s1_ry_q;

  logic                 s2_vld_q, s2_last_q, s2_str_q, s2_pos_q;
  logic signed [PW-1:0] s2_lhs_q, s2_rhs_q;

  // Scale corners to Q8
  assign ya8 = {seg_i.ya, 8'b0};
  assign yb8 = {seg_i.yb, 8'b0};
  assign xa8 = {seg_i.xa, 8'b0};

  always_comb begin
    straddle = ((ya8 < py_i) && (yb8 >= py_i)) || ((yb8 < py_i) && (ya8 >= py_i));
    dx_d = {seg_i.xb[pip_pkg::CRD_W-1], seg_i.xb} - {seg_i.xa[pip_pkg::CRD_W-1], seg_i.xa};
    dy_d = {seg_i.yb[pip_pkg::CRD_W-1], seg_i.yb} - {seg_i.ya[pip_pkg::CRD_W-1], seg_i.ya};
    ry_d = {py_i[pip_pkg::PT_W-1], py_i} - {ya8[pip_pkg::PT_W-1], ya8};
    rx_d = {px_i[pip_pkg::PT_W-1], px_i} - {xa8[pip_pkg::PT_W-1], xa8};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= seg_i.vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= seg_i.last;
    s1_str_q  <= straddle;
    s1_dx_q   <= dx_d;
    s1_dy_q   <= dy_d;
    s1_rx_q   <= rx_d;
    s1_ry_q   <= ry_d;

    s2_last_q <= s1_last_q;
    s2_str_q  <= s1_str_q;
    s2_pos_q  <= (s1_dy_q > 0);
    s2_lhs_q  <= s1_ry_q * s1_dx_q;
    s2_rhs_q  <= s1_rx_q * s1_dy_q;
  end

  // A falling edge flips the sense of the compare
  always_comb begin
    xing_o.vld  = s2_vld_q;
    xing_o.last = s2_last_q;
    xing_o.hit  = s2_str_q && (s2_pos_q ? (s2_lhs_q < s2_rhs_q) : (s2_lhs_q > s2_rhs_q));
  end

endmodule

`default_nettype wire

/* sv/pip_walk.sv */
// Back end: vertex memory, store execution and the edge walk of a query.
// Depends on pip_pkg and pip_edge.
`default_nettype none

module pip_walk #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pip_pkg::cmd_t             cmd_i,
  input  wire logic                      cmd_vld_i,
  output logic                           cmd_pop_o,
  input  wire logic [pip_pkg::CNT_W-1:0] vertex_count_i,
  output logic                           res_vld_o,
  output logic                           res_inside_o,
  input  wire logic                      res_rdy_i
);

  localparam int AW = $clog2(MAX_VERTICES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic [AW-1:0]                   idx_q, last_q, last_d;
  logic                            lead_q;
  logic                            parity_q, inside_q;
  logic signed [pip_pkg::PT_W-1:0] px_q, py_q;

  logic signed [pip_pkg::CRD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [pip_pkg::CRD_W-1:0] mem_y [MAX_VERTICES];
  logic                             mem_we, rd_en;
  logic [AW-1:0]                    rd_addr;
  logic signed [pip_pkg::CRD_W-1:0] rd_x_q, rd_y_q, prv_x_q, prv_y_q;
  logic                             rd_vld_q, rd_pair_q, rd_last_q;

  pip_pkg::seg_t  seg;
  pip_pkg::xing_t xing;

  assign cmd_pop_o    = (state_q == S_IDLE) && cmd_vld_i;
  assign mem_we       = cmd_pop_o && (cmd_i.op == pip_pkg::OP_STORE);
  assign rd_en        = (state_q == S_WALK);
  assign rd_addr      = lead_q ? last_q : idx_q;
  assign res_vld_o    = (state_q == S_DONE);
  assign res_inside_o = inside_q;

  // Clamp the count to the memory depth, then take the last slot
  always_comb begin
    if (int'(vertex_count_i) > MAX_VERTICES) begin
      last_d = AW'(MAX_VERTICES - 1);
    end else begin
      last_d = AW'(int'(vertex_count_i) - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[AW'(cmd_i.vidx)] <= cmd_i.vx;
      mem_y[AW'(cmd_i.vidx)] <= cmd_i.vy;
    end
    if (rd_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  // Tag each read: the lead read only seeds the predecessor corner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_pair_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      rd_pair_q <= rd_en && !lead_q;
      rd_last_q <= rd_en && !lead_q && (idx_q == last_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prv_x_q <= rd_x_q;
      prv_y_q <= rd_y_q;
    end
  end

  always_comb begin
    seg.vld  = rd_vld_q && rd_pair_q;
    seg.last = rd_last_q;
    seg.xa   = rd_x_q;
    seg.ya   = rd_y_q;
    seg.xb   = prv_x_q;
    seg.yb   = prv_y_q;
  end

  pip_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .px_i   (px_q),
    .py_i   (py_q),
    .xing_o (xing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      last_q   <= '0;
      lead_q   <= 1'b0;
      parity_q <= 1'b0;
      inside_q <= 1'b0;
      px_q     <= '0;
      py_q     <= '0;
    end else begin
      if (xing.vld && xing.hit) begin
        parity_q <= !parity_q;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && (cmd_i.op == pip_pkg::OP_QUERY)) begin
            px_q     <= cmd_i.px;
            py_q     <= cmd_i.py;
            parity_q <= 1'b0;
            if (vertex_count_i == '0) begin
              inside_q <= 1'b0;
              state_q  <= S_DONE;
            end else begin
              last_q  <= last_d;
              idx_q   <= '0;
              lead_q  <= 1'b1;
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (lead_q) begin
            lead_q <= 1'b0;
          end else if (idx_q == last_q) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_DRAIN: begin
          if (xing.vld && xing.last) begin
            inside_q <= parity_q ^ xing.hit;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_rdy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/point_in_polygon_test.sv */
// Top level of the even-odd ray-casting point-in-polygon test.
// Depends on pip_pkg, pip_front, pip_edge and pip_walk.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    func, vertex_index, vertex_x/y, point_x/y
//   out       output     out_valid_o / out_ready_i  inside_res
//   apb       input      psel/penable/pwrite        paddr, pwdata, prdata (vertex_count)
//
// A store item passes through the queue and then the vertex memory write.
// A query is popped from the queue, then makes n + 1 reads of the single vertex
// memory read port (one edge per cycle), n being the clamped vertex count; each
// edge passes the registered stages of the crossing test, and the result is
// handed to the output register. A query with no vertices goes straight to its
// result. Reset clears the queue, the walker and the output register; the
// vertex memory is not cleared. A stalled output holds the walker in its result
// state while the queue keeps taking up to two more items.
`default_nettype none

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [pip_pkg::IDX_W-1:0]         vertex_index_i,
  input  wire logic signed [pip_pkg::CRD_W-1:0]  vertex_x_i,
  input  wire logic signed [pip_pkg::CRD_W-1:0]  vertex_y_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]   point_x_i,
  input  wire logic signed [pip_pkg::PT_W-1:0]   point_y_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   inside_res_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [pip_pkg::CNT_W-1:0] vertex_count_q;
  logic                      cfg_wr;

  pip_pkg::cmd_t cmd;
  logic          cmd_vld, cmd_pop;
  logic          res_vld, res_inside, res_rdy;
  logic          out_valid_q, inside_q;

  // ---------------------------------------------------------------------------
  // Configuration: one register, word address in paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_wr && (paddr[2] == pip_pkg::REG_VERTEX_COUNT)) begin
      vertex_count_q <= pwdata[pip_pkg::CNT_W-1:0];
    end
  end

  // Unknown register indexes read as zero
  always_comb begin
    if (paddr[2] == pip_pkg::REG_VERTEX_COUNT) begin
      prdata = {{(32-pip_pkg::CNT_W){1'b0}}, vertex_count_q};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Front: accept, classify, queue
  // ---------------------------------------------------------------------------
  pip_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .vertex_index_i (vertex_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .cmd_o          (cmd),
    .cmd_vld_o      (cmd_vld),
    .cmd_pop_i      (cmd_pop)
  );

  // ---------------------------------------------------------------------------
  // Back: vertex memory and edge walk
  // ---------------------------------------------------------------------------
  pip_walk #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_vld_i      (cmd_vld),
    .cmd_pop_o      (cmd_pop),
    .vertex_count_i (vertex_count_q),
    .res_vld_o      (res_vld),
    .res_inside_o   (res_inside),
    .res_rdy_i      (res_rdy)
  );

  // ---------------------------------------------------------------------------
  // Output register: take a new result when empty or being drained this cycle
  // ---------------------------------------------------------------------------
  assign res_rdy = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_rdy) begin
      out_valid_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_rdy && res_vld) begin
      inside_q <= res_inside;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_vld)
    else $error("back end popped an empty command queue");

  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && !res_rdy) |=> (res_vld && $stable(res_inside)))
    else $error("pending result dropped or changed while output stalled");

  a_res_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld && res_rdy) |=> (out_valid_o && (inside_res_o == $past(res_inside))))
    else $error("result lost on transfer into the output register");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == pip_pkg::REG_VERTEX_COUNT))
      |=> (vertex_count_q == $past(pwdata[pip_pkg::CNT_W-1:0])))
    else $error("vertex_count write not taken");

endmodule

`default_nettype wire
